@@ rtl/core/iol_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Shared constants, command and response payload types, and cell control codes.
// ----------------------------------------------------------------------------
package iol_pkg;

    // Default sizing of the list.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths of the command and response beats.
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ       = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd6;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd7;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Cell control codes: what a cell loads at the next edge.
    localparam int CELL_CTL_W = 2;
    localparam logic [CELL_CTL_W-1:0] CELL_HOLD      = 2'd0;
    localparam logic [CELL_CTL_W-1:0] CELL_FROM_LOW  = 2'd1;
    localparam logic [CELL_CTL_W-1:0] CELL_FROM_HIGH = 2'd2;
    localparam logic [CELL_CTL_W-1:0] CELL_LOAD      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word_in;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0]   word_out;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

@@ rtl/core/iol_chan_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel
// One stream channel carrying valid, ready and a typed payload per beat.
// ----------------------------------------------------------------------------
interface iol_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/indexed_ordered_list.sv @@
// Latency: a response beat is valid on the cycle after its command beat is accepted.
// Throughput: one command per cycle while the response register is free or being taken;
// cells from the slot up move in parallel, so insert and remove at any index never iterate.
// The command side stays ready while the response register is empty or being taken.
// Reset clears the element count, the direction flag and the response valid flag;
// cell contents are undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// Indexed ordered list
// Bounded double-ended list of words held in a row of shifting cells, with
// push, pop, insert, read, remove and reverse, one response per command.
// ----------------------------------------------------------------------------
module indexed_ordered_list #(
    parameter int DEPTH      = iol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iol_chan_if.sink   i_cmd,
    iol_chan_if.source o_rsp
);
    import iol_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    // State.
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  n_len;
    logic           r_rev;
    logic           n_rev;
    t_rsp           r_rsp;
    t_rsp           n_rsp;
    logic           r_rsp_valid;

    // Command decode.
    logic                  fire;
    logic [OP_W-1:0]       op;
    logic [CW-1:0]         pos_c;
    logic [CW-1:0]         len_c;
    logic [CW-1:0]         lidx;
    logic [CW-1:0]         slot_c;
    logic [SW-1:0]         slot;
    logic                  do_put;
    logic                  do_take;
    logic                  do_read;
    logic                  is_full;
    logic                  is_empty;
    logic [STATUS_W-1:0]   n_status;
    logic [DATA_WIDTH-1:0] new_word;
    logic [DATA_WIDTH-1:0] sel_word;

    logic [DATA_WIDTH-1:0]   cell_q   [DEPTH];
    logic [CELL_CTL_W-1:0]   cell_ctl [DEPTH];

    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign fire        = i_cmd.valid && i_cmd.ready;

    assign op       = i_cmd.payload.operation;
    assign pos_c    = CW'(i_cmd.payload.position);
    assign len_c    = CW'(r_len);
    assign is_full  = (r_len == LW'(DEPTH));
    assign is_empty = (r_len == '0);
    assign new_word = DATA_WIDTH'(i_cmd.payload.word_in);

    // Decide the action, the logical index and the status of the command.
    always_comb begin
        do_put   = 1'b0;
        do_take  = 1'b0;
        do_read  = 1'b0;
        lidx     = '0;
        n_status = ST_OK;
        n_rev    = r_rev;
        unique case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                lidx = (op == OP_PUSH_BACK) ? len_c : '0;
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_put = 1'b1;
                end
            end
            OP_INSERT: begin
                lidx = pos_c;
                if (pos_c > len_c) begin
                    n_status = ST_RANGE;
                end else if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_put = 1'b1;
                end
            end
            OP_READ, OP_REMOVE: begin
                lidx = pos_c;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else if (pos_c >= len_c) begin
                    n_status = ST_RANGE;
                end else if (op == OP_READ) begin
                    do_read = 1'b1;
                end else begin
                    do_take = 1'b1;
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                lidx = (op == OP_POP_BACK) ? (len_c - CW'(1)) : '0;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_take = 1'b1;
                end
            end
            default: begin
                n_rev = !r_rev;
            end
        endcase
    end

    // Map the logical index to a storage slot, honoring the direction flag.
    always_comb begin
        if (!r_rev) begin
            slot_c = lidx;
        end else if (do_put) begin
            slot_c = len_c - lidx;
        end else begin
            slot_c = len_c - CW'(1) - lidx;
        end
    end
    assign slot = slot_c[SW-1:0];

    assign sel_word = cell_q[slot];

    // Next count and the response beat.
    always_comb begin
        n_len = r_len;
        if (fire && do_put) begin
            n_len = r_len + LW'(1);
        end else if (fire && do_take) begin
            n_len = r_len - LW'(1);
        end
        n_rsp.word_out = (do_read || do_take) ? WORD_W'(sel_word) : '0;
        n_rsp.count    = COUNT_W'(n_len);
        n_rsp.status   = n_status;
    end

    // Row of cells: each one shifts toward or away from its neighbor.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] low_w;
        logic [DATA_WIDTH-1:0] high_w;

        if (k == 0) begin : g_first
            assign low_w = '0;
        end else begin : g_mid_low
            assign low_w = cell_q[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign high_w = '0;
        end else begin : g_mid_high
            assign high_w = cell_q[k+1];
        end

        always_comb begin
            cell_ctl[k] = CELL_HOLD;
            if (fire && do_put) begin
                if (SW'(k) > slot) begin
                    cell_ctl[k] = CELL_FROM_LOW;
                end else if (SW'(k) == slot) begin
                    cell_ctl[k] = CELL_LOAD;
                end
            end else if (fire && do_take && (k != DEPTH - 1)) begin
                if (SW'(k) >= slot) begin
                    cell_ctl[k] = CELL_FROM_HIGH;
                end
            end
        end

        iol_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[k]),
            .i_low  (low_w),
            .i_high (high_w),
            .i_word (new_word),
            .o_word (cell_q[k])
        );
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_rev       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_len <= n_len;
                r_rev <= n_rev;
            end
            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // The count never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("list count above capacity");

    // An accepted command always leaves a response beat in the register.
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_rsp_valid)
        else $error("accepted command produced no response");

    // The count moves by at most one element per cycle.
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == $past(r_len)) || (r_len == $past(r_len) + LW'(1)) ||
        (r_len == $past(r_len) - LW'(1)))
        else $error("count moved by more than one");

    // A full status leaves the list at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (n_status == ST_FULL)) |=> (r_len == LW'(DEPTH)))
        else $error("full status with room left");

    // An empty status leaves the list empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (n_status == ST_EMPTY)) |=> (r_len == '0))
        else $error("empty status with elements present");

endmodule

@@ rtl/core/iol_cell.sv @@
// ----------------------------------------------------------------------------
// List storage cell
// Holds one word and, on command, takes its lower or upper neighbor's word,
// loads a new word, or holds.
// ----------------------------------------------------------------------------
module iol_cell #(
    parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic [iol_pkg::CELL_CTL_W-1:0]  i_ctl,
    input  logic [DATA_WIDTH-1:0]           i_low,
    input  logic [DATA_WIDTH-1:0]           i_high,
    input  logic [DATA_WIDTH-1:0]           i_word,
    output logic [DATA_WIDTH-1:0]           o_word
);
    import iol_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    // Select the next content of the cell.
    always_comb begin
        unique case (i_ctl)
            CELL_FROM_LOW:  n_word = i_low;
            CELL_FROM_HIGH: n_word = i_high;
            CELL_LOAD:      n_word = i_word;
            default:        n_word = r_word;
        endcase
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
